// ===== hw/rtl/htfd_pkg.sv =====
// Package for the sensor frame decoder: frame record type, CRC and
// decode constants, and the byte-wide CRC-16 update function.
// No dependencies.
package htfd_pkg;

  localparam int unsigned FrameBytes = 8;
  localparam int unsigned PosW       = 3;

  // Byte positions inside a frame that matter to the assembler.
  localparam logic [PosW-1:0] POS_HUMID_HI = 3'd2;
  localparam logic [PosW-1:0] POS_HUMID_LO = 3'd3;
  localparam logic [PosW-1:0] POS_TEMP_HI  = 3'd4;
  localparam logic [PosW-1:0] POS_TEMP_LO  = 3'd5;
  localparam logic [PosW-1:0] POS_CRC_LO   = 3'd6;
  localparam logic [PosW-1:0] POS_CRC_HI   = 3'd7;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // floor(x * RECIP_TEN / 2^RECIP_SHIFT) equals x / 10 for 0 <= x <= 32768.
  localparam logic [31:0] RECIP_TEN   = 32'd52429;
  localparam int unsigned RECIP_SHIFT = 19;

  // One completed frame, as handed from the assembler to the decoder.
  typedef struct packed {
    logic        crc_ok;
    logic [15:0] humid_raw;
    logic [15:0] temp_raw;
  } frame_t;

  // Push side of the frame queue.
  typedef struct packed {
    logic   valid;
    frame_t frame;
  } frame_push_t;

  // Reflected CRC-16 update over one byte, least significant bit first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

// ===== hw/rtl/htfd_front.sv =====
// Front part of the frame decoder: counts bytes, runs the CRC and collects
// the data bytes, then hands a frame record to the queue on the last byte.
// Depends on htfd_pkg.
module htfd_front
  import htfd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  input  logic        q_full_i,
  output frame_push_t q_push_o
);

  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     crc_q, crc_d;
  logic [15:0]     humid_q, temp_q;
  logic [7:0]      crc_lo_q;
  logic            last_byte;
  logic            accept;

  // Only the last byte of a frame needs room in the queue.
  assign last_byte = (pos_q == POS_CRC_HI);
  assign full      = last_byte && q_full_i;
  assign accept    = push && !full;

  // Byte position and running CRC.
  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (accept) begin
      pos_d = pos_q + 1'b1;
      if (last_byte) begin
        crc_d = CRC_INIT;
      end else if (pos_q < POS_CRC_LO) begin
        crc_d = crc16_byte(crc_q, rx_byte_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= CRC_INIT;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  // Capture the bytes that the frame record needs.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      unique case (pos_q)
        POS_HUMID_HI: humid_q[15:8] <= rx_byte_i;
        POS_HUMID_LO: humid_q[7:0]  <= rx_byte_i;
        POS_TEMP_HI:  temp_q[15:8]  <= rx_byte_i;
        POS_TEMP_LO:  temp_q[7:0]   <= rx_byte_i;
        POS_CRC_LO:   crc_lo_q      <= rx_byte_i;
        default: ;
      endcase
    end
  end

  // The received CRC is complete with the byte now arriving.
  assign q_push_o.valid           = accept && last_byte;
  assign q_push_o.frame.crc_ok    = (crc_q == {rx_byte_i, crc_lo_q});
  assign q_push_o.frame.humid_raw = humid_q;
  assign q_push_o.frame.temp_raw  = temp_q;

endmodule

// ===== hw/rtl/htfd_fifo.sv =====
// Short queue of frame records between the assembler and the decoder.
// Depends on htfd_pkg.
module htfd_fifo
  import htfd_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  frame_push_t push_i,
  output logic        full_o,
  output logic        valid_o,
  output frame_t      data_o,
  input  logic        pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  frame_t          mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Storage, written at the tail.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.frame;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/htfd_back.sv =====
// Back part of the frame decoder: splits humidity and temperature tenths
// into whole and tenths parts over two stages and holds the result item.
// Depends on htfd_pkg.
module htfd_back
  import htfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  frame_t             q_data_i,
  output logic               q_pop_o,
  output logic               empty,
  input  logic               pop,
  output logic               crc_ok_o,
  output logic signed [12:0] temp_whole_o,
  output logic signed [4:0]  temp_tenths_o,
  output logic signed [12:0] humid_whole_o,
  output logic signed [4:0]  humid_tenths_o
);

  // Stage one: magnitude and reciprocal product.
  logic        s1_v_q, out_v_q;
  logic        s1_crc_ok_q;
  logic        s1_h_neg_q, s1_t_neg_q;
  logic [15:0] s1_h_abs_q, s1_t_abs_q;
  logic [31:0] s1_h_prod_q, s1_t_prod_q;
  logic [15:0] h_abs, t_abs;
  logic        out_ready, s1_adv;

  assign out_ready = !out_v_q || pop;
  assign s1_adv    = !s1_v_q || out_ready;
  assign q_pop_o   = q_valid_i && s1_adv;
  assign empty     = !out_v_q;

  assign h_abs = q_data_i.humid_raw[15] ? (~q_data_i.humid_raw + 16'd1)
                                        : q_data_i.humid_raw;
  assign t_abs = q_data_i.temp_raw[15] ? (~q_data_i.temp_raw + 16'd1)
                                       : q_data_i.temp_raw;

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s1_crc_ok_q <= q_data_i.crc_ok;
      s1_h_neg_q  <= q_data_i.humid_raw[15];
      s1_t_neg_q  <= q_data_i.temp_raw[15];
      s1_h_abs_q  <= h_abs;
      s1_t_abs_q  <= t_abs;
      s1_h_prod_q <= 32'(h_abs) * RECIP_TEN;
      s1_t_prod_q <= 32'(t_abs) * RECIP_TEN;
    end
  end

  // Stage two: quotient, remainder and sign restore.
  logic [11:0] h_quo, t_quo;
  logic [15:0] h_rem, t_rem;
  logic [12:0] h_whole, t_whole;
  logic [4:0]  h_tenths, t_tenths;

  always_comb begin
    h_quo    = s1_h_prod_q[RECIP_SHIFT +: 12];
    t_quo    = s1_t_prod_q[RECIP_SHIFT +: 12];
    h_rem    = s1_h_abs_q - ({4'd0, h_quo} << 3) - ({4'd0, h_quo} << 1);
    t_rem    = s1_t_abs_q - ({4'd0, t_quo} << 3) - ({4'd0, t_quo} << 1);
    h_whole  = s1_h_neg_q ? (13'd0 - {1'b0, h_quo}) : {1'b0, h_quo};
    t_whole  = s1_t_neg_q ? (13'd0 - {1'b0, t_quo}) : {1'b0, t_quo};
    h_tenths = s1_h_neg_q ? (5'd0 - {1'b0, h_rem[3:0]}) : {1'b0, h_rem[3:0]};
    t_tenths = s1_t_neg_q ? (5'd0 - {1'b0, t_rem[3:0]}) : {1'b0, t_rem[3:0]};
  end

  // Output register holding the oldest result item.
  always_ff @(posedge clk_i) begin
    if (s1_v_q && out_ready) begin
      crc_ok_o       <= s1_crc_ok_q;
      humid_whole_o  <= h_whole;
      humid_tenths_o <= h_tenths;
      temp_whole_o   <= t_whole;
      temp_tenths_o  <= t_tenths;
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_q <= q_valid_i;
      end
      if (out_ready) begin
        out_v_q <= s1_v_q;
      end
    end
  end

endmodule

// ===== hw/rtl/humidity_temp_frame_decoder.sv =====
// Top level of the sensor frame decoder: byte assembler, frame queue and
// decoder. Depends on htfd_pkg, htfd_front, htfd_fifo and htfd_back.
//
//   Channel  Handshake      Item
//   input    push / full    rx_byte_i, one frame byte, byte 0 first
//   result   empty / pop    crc_ok_o, humid/temp whole and tenths parts
//
// One byte is taken every cycle while full is low; full rises only on the last
// byte of a frame while the frame queue is full. A result item passes through
// the frame queue, stage one and the output register after the last byte of
// its frame is taken.
// Reset clears byte position, CRC, queue and all valid flags.
// A stalled result side fills the queue, then holds off the next frame end.
module humidity_temp_frame_decoder
  import htfd_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         rx_byte_i,
  output logic               empty,
  input  logic               pop,
  output logic               crc_ok_o,
  output logic signed [12:0] temp_whole_o,
  output logic signed [4:0]  temp_tenths_o,
  output logic signed [12:0] humid_whole_o,
  output logic signed [4:0]  humid_tenths_o
);

  frame_push_t q_push;
  frame_t      q_data;
  logic        q_full, q_valid, q_pop;

  htfd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .rx_byte_i (rx_byte_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push)
  );

  htfd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  htfd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_data_i       (q_data),
    .q_pop_o        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .crc_ok_o       (crc_ok_o),
    .temp_whole_o   (temp_whole_o),
    .temp_tenths_o  (temp_tenths_o),
    .humid_whole_o  (humid_whole_o),
    .humid_tenths_o (humid_tenths_o)
  );

endmodule
